/* rtl/core/hsplit_pkg.sv */
// Package for the HTTP header/body splitter: word types, phase codes,
// header-name table and sizing constants. Depends on nothing.
package hsplit_pkg;

  // Default width of the length and body counters
  localparam int unsigned CountBitsDef = 32;

  // Length of "content-length" and the separator count that ends the header
  localparam int unsigned NameLen = 14;
  localparam logic [2:0]  HdrEnd  = 3'd4;

  // Bytes of interest
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;

  // Input word kinds
  localparam logic KindNewPage = 1'b0;
  localparam logic KindByte    = 1'b1;

  // Header parse phases, one-hot
  typedef enum logic [4:0] {
    PhIdle  = 5'b00001,
    PhMatch = 5'b00010,
    PhColon = 5'b00100,
    PhBlank = 5'b01000,
    PhDigit = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } hsplit_in_t;

  typedef struct packed {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        header_done;
    logic [31:0] body_count;
    logic [31:0] content_length;
    logic        page_done;
    logic        overflow;
  } hsplit_out_t;

  // Lower-case header name, one character per match position
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h6c; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // ASCII upper case to lower case, everything else unchanged
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= ChUpA && b <= ChUpZ) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

/* rtl/core/hsplit_parse.sv */
// Header/body splitter state: separator counter, header-name matcher,
// length parser and body counter. One result word per accepted word.
// Depends on hsplit_pkg.
module hsplit_parse #(
  parameter int unsigned CountBits = hsplit_pkg::CountBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     acc_i,
  input  hsplit_pkg::hsplit_in_t   word_i,
  output hsplit_pkg::hsplit_out_t  res_o
);
  import hsplit_pkg::*;

  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};

  logic [2:0]           sep_q, sep_d;
  logic [3:0]           pos_q, pos_d;
  phase_e               phase_q, phase_d;
  logic [CountBits-1:0] len_q, len_d;
  logic [CountBits-1:0] cnt_q, cnt_d;

  logic [7:0]           b;
  logic                 is_digit;
  logic [CountBits+3:0] len_x10;
  logic                 body;

  assign b        = word_i.data_byte;
  assign is_digit = b inside {[ChZero:ChNine]};

  // length * 10 + digit, with the carry bits kept for saturation
  assign len_x10 = (CountBits+4)'({len_q, 3'b000}) + (CountBits+4)'({len_q, 1'b0})
                 + (CountBits+4)'(b - ChZero);

  // Next state
  always_comb begin
    sep_d   = sep_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    body    = 1'b0;
    if (word_i.kind == KindNewPage) begin
      sep_d   = '0;
      pos_d   = '0;
      phase_d = PhIdle;
      len_d   = '0;
      cnt_d   = '0;
    end else if (sep_q == HdrEnd) begin
      body = 1'b1;
      if (cnt_q != CntMax) begin
        cnt_d = cnt_q + 1'b1;
      end
    end else begin
      // header parse
      case (phase_q)
        PhMatch: begin
          if (to_lower(b) == name_char(pos_q)) begin
            if (pos_q == 4'(NameLen - 1)) begin
              len_d   = '0;
              phase_d = PhColon;
              pos_d   = '0;
            end else begin
              pos_d = pos_q + 4'd1;
            end
          end else begin
            phase_d = PhIdle;
            pos_d   = '0;
          end
        end
        PhColon: begin
          phase_d = PhBlank;
        end
        PhBlank, PhDigit: begin
          if (is_digit) begin
            if (len_x10[CountBits+3:CountBits] != 4'd0) begin
              len_d = CntMax;
            end else begin
              len_d = len_x10[CountBits-1:0];
            end
            phase_d = PhDigit;
          end else if (phase_q == PhBlank && (b == ChSpace || b == ChTab)) begin
            phase_d = PhBlank;
          end else begin
            phase_d = PhIdle;
          end
        end
        default: begin
          phase_d = PhIdle;
          pos_d   = '0;
        end
      endcase
      // separator counter; CR, LF in the header opens a name match
      if (!sep_q[0] && b == ChCr) begin
        sep_d = sep_q + 3'd1;
      end else if (sep_q[0] && b == ChLf) begin
        sep_d = sep_q + 3'd1;
        pos_d = '0;
        if (sep_q + 3'd1 < HdrEnd) begin
          phase_d = PhMatch;
        end else begin
          phase_d = PhIdle;
        end
      end else begin
        sep_d = '0;
      end
    end
  end

  // Result word from the updated state
  always_comb begin
    res_o.body_valid     = body;
    res_o.body_byte      = body ? b : 8'h00;
    res_o.header_done    = (sep_d == HdrEnd);
    res_o.body_count     = 32'(cnt_d);
    res_o.content_length = 32'(len_d);
    res_o.page_done      = (len_d != '0) && (cnt_d == len_d);
    res_o.overflow       = (len_d != '0) && (cnt_d > len_d);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= '0;
      pos_q   <= '0;
      phase_q <= PhIdle;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (acc_i) begin
      sep_q   <= sep_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_sep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sep_q <= HdrEnd) else $error("separator count beyond header end");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < 4'(NameLen)) else $error("match position out of range");
  a_pos_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != '0 |-> phase_q == PhMatch) else $error("match position outside match");
  a_body_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sep_q == HdrEnd |-> phase_q == PhIdle) else $error("parsing inside body");
  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && word_i.kind == KindByte && sep_q == HdrEnd && cnt_q != CntMax
    |=> cnt_q == $past(cnt_q) + 1'b1) else $error("body count did not advance");
`endif

endmodule

/* rtl/core/hsplit_skid.sv */
// Output register with a skid stage, so a word is taken while a result waits.
// Depends on hsplit_pkg.
module hsplit_skid (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hsplit_pkg::hsplit_out_t  res_i,
  input  logic                     res_valid_i,
  output logic                     res_ready_o,
  output hsplit_pkg::hsplit_out_t  out_data_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i
);
  import hsplit_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  hsplit_out_t out_q, out_d;
  hsplit_out_t skid_q, skid_d;
  logic        res_acc;

  assign res_ready_o = !skid_valid_q;
  assign res_acc     = res_valid_i && res_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Slot movement
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_i;
        out_valid_d = res_acc;
      end
    end else if (res_acc) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef NO_ASSERTIONS
  a_skid_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid word without output word");
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && res_acc |=> skid_valid_q)
    else $error("stalled word lost");
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> out_valid_q && !skid_valid_q)
    else $error("skid word not moved forward");
`endif

endmodule

/* rtl/core/http_header_body_splitter_core.sv */
// Top level of the HTTP header/body splitter: parser state and output skid.
// Depends on hsplit_pkg, hsplit_parse and hsplit_skid.
//
//   channel  | valid       | ready       | word
//   ---------+-------------+-------------+-------------------------
//   input    | in_valid_i  | in_ready_o  | in_data_i  (hsplit_in_t)
//   output   | out_valid_o | out_ready_i | out_data_o (hsplit_out_t)
//
// One word in per cycle while in_ready_o is high; its result word is
// registered in the output register, or in the skid word on a stall. The
// parser state updates in the cycle a word is taken. Reset clears the
// separator counter, matcher, length and body count. An output stall is
// absorbed by one skid word; in_ready_o drops only when it is occupied.
module http_header_body_splitter_core #(
  parameter int unsigned COUNT_BITS = hsplit_pkg::CountBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  hsplit_pkg::hsplit_in_t   in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output hsplit_pkg::hsplit_out_t  out_data_o
);
  import hsplit_pkg::*;

  logic        in_acc;
  hsplit_out_t res;

  assign in_acc = in_valid_i && in_ready_o;

  hsplit_parse #(
    .CountBits(COUNT_BITS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .word_i (in_data_i),
    .res_o  (res)
  );

  hsplit_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_valid_i (in_valid_i),
    .res_ready_o (in_ready_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for http_header_body_splitter_core. It drives bytes and page starts,
// predicts every result word in lock-step and compares each field.
// Depends on hsplit_pkg and the splitter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsplit_pkg::*;

  localparam int unsigned CountBits   = CountBitsDef;
  localparam int          RandomWords = 1100;
  localparam int          CycleLimit  = 400_000;
  localparam int          ReportMax   = 10;

  // Directed stimulus row; a typed expectation replaces the predicted one
  typedef struct {
    hsplit_in_t  word;
    bit          typed;
    hsplit_out_t want;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  hsplit_in_t  in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  hsplit_out_t out_data;

  int src_idle_pct = 31;
  int dst_idle_pct = 63;
  int words_sent   = 0;
  int bad_words    = 0;
  int cycles       = 0;

  hsplit_out_t pending_results[$];
  dir_row_t    dir_rows[$];
  string       name_text = "content-length";

  // Predictor state
  logic [2:0]           sep_cnt  = '0;
  int                   name_pos = 0;
  phase_e               phase    = PhIdle;
  logic [CountBits-1:0] len_val  = '0;
  logic [CountBits-1:0] body_cnt = '0;

  http_header_body_splitter_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Work out the result word of one accepted input word and advance the state
  function automatic hsplit_out_t predict_split(input hsplit_in_t w);
    hsplit_out_t          r;
    logic [7:0]           b;
    logic [7:0]           lc;
    logic [CountBits+3:0] wide;
    r = '0;
    b = w.data_byte;
    if (w.kind == KindNewPage) begin
      sep_cnt  = '0;
      name_pos = 0;
      phase    = PhIdle;
      len_val  = '0;
      body_cnt = '0;
    end else if (sep_cnt >= HdrEnd) begin
      r.body_valid = 1'b1;
      r.body_byte  = b;
      if (body_cnt != '1) begin
        body_cnt = body_cnt + 1'b1;
      end
    end else begin
      lc = (b >= ChUpA && b <= ChUpZ) ? b + 8'd32 : b;
      // header parse
      case (phase)
        PhMatch: begin
          if (name_pos < NameLen && lc == name_text[name_pos]) begin
            name_pos++;
            if (name_pos == NameLen) begin
              len_val  = '0;
              phase    = PhColon;
              name_pos = 0;
            end
          end else begin
            phase    = PhIdle;
            name_pos = 0;
          end
        end
        PhColon: begin
          phase = PhBlank;
        end
        PhBlank, PhDigit: begin
          if (b >= ChZero && b <= ChNine) begin
            wide = {4'b0000, len_val};
            wide = wide * (CountBits+4)'(10) + (CountBits+4)'(b - ChZero);
            if (wide[CountBits+3:CountBits] != '0) begin
              len_val = '1;
            end else begin
              len_val = wide[CountBits-1:0];
            end
            phase = PhDigit;
          end else if (phase == PhBlank && (b == ChSpace || b == ChTab)) begin
            // blanks before the number are skipped
          end else begin
            phase = PhIdle;
          end
        end
        default: begin
          phase    = PhIdle;
          name_pos = 0;
        end
      endcase
      // separator counter: CR on even, LF on odd, anything else clears
      if (!sep_cnt[0] && b == ChCr) begin
        sep_cnt = sep_cnt + 1'b1;
      end else if (sep_cnt[0] && b == ChLf) begin
        sep_cnt  = sep_cnt + 1'b1;
        name_pos = 0;
        phase    = (sep_cnt < HdrEnd) ? PhMatch : PhIdle;
      end else begin
        sep_cnt = '0;
      end
    end
    r.header_done    = (sep_cnt >= HdrEnd);
    r.body_count     = 32'(body_cnt);
    r.content_length = 32'(len_val);
    r.page_done      = (len_val != '0) && (body_cnt == len_val);
    r.overflow       = (len_val != '0) && (body_cnt > len_val);
    return r;
  endfunction

  function automatic string fmt_word(input hsplit_out_t w);
    return $sformatf("bv=%0d byte=%02h hdr=%0d cnt=%0d len=%0d done=%0d ovf=%0d",
                     w.body_valid, w.body_byte, w.header_done, w.body_count,
                     w.content_length, w.page_done, w.overflow);
  endfunction

  // Result checker: outputs sampled mid-cycle, taken at the next rising edge
  always @(negedge clk) begin
    hsplit_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (bad_words < ReportMax) begin
          $display("%0t: result word with none expected: %s", $realtime, fmt_word(out_data));
        end
        bad_words++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.body_valid !== want.body_valid ||
            out_data.body_byte !== want.body_byte ||
            out_data.header_done !== want.header_done ||
            out_data.body_count !== want.body_count ||
            out_data.content_length !== want.content_length ||
            out_data.page_done !== want.page_done ||
            out_data.overflow !== want.overflow) begin
          if (bad_words < ReportMax) begin
            $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                     fmt_word(want), fmt_word(out_data));
          end
          bad_words++;
        end
      end
    end
  end

  // Offer one word, with random gaps, and record its expected result once taken
  task automatic send_word(input hsplit_in_t w, input bit typed, input hsplit_out_t typed_want);
    bit          taken;
    hsplit_out_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    pred = predict_split(w);
    pending_results.push_back(typed ? typed_want : pred);
    words_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_word(hsplit_in_t'{kind: KindByte, data_byte: b}, 1'b0, '0);
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) begin
      put_byte(s[i]);
    end
  endtask

  task automatic new_page();
    send_word(hsplit_in_t'{kind: KindNewPage, data_byte: 8'($urandom_range(255))}, 1'b0, '0);
  endtask

  // Length header with random case, separator, blanks and number shape
  task automatic put_length_line();
    logic [7:0] c;
    int         pick;
    foreach (name_text[i]) begin
      c = name_text[i];
      if (c >= "a" && c <= "z" && $urandom_range(1)) begin
        c = c - 8'd32;
      end
      put_byte(c);
    end
    put_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : ":");
    repeat ($urandom_range(0, 3)) put_byte($urandom_range(1) ? ChSpace : ChTab);
    pick = $urandom_range(99);
    if (pick < 65) begin
      put_text($sformatf("%0d", $urandom_range(0, 40)));
    end else if (pick < 75) begin
      // long number, can saturate the length
      repeat ($urandom_range(10, 14)) put_byte(8'(ChZero + $urandom_range(9)));
    end else if (pick < 83) begin
      // name with no digits at all
    end else if (pick < 91) begin
      put_byte($urandom_range(1) ? "-" : "+");
      put_text("12");
    end else begin
      put_text($sformatf("%0d", $urandom_range(1, 9)));
      put_byte(8'($urandom_range(255)));
      put_text("3");
    end
  endtask

  // Noise, heavy on CR and LF
  task automatic put_noise();
    repeat ($urandom_range(1, 16)) begin
      case ($urandom_range(3))
        0:       put_byte(ChCr);
        1:       put_byte(ChLf);
        default: put_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  // One response: status line, header lines, blank line and a body
  task automatic put_page();
    int n;
    int k;
    if ($urandom_range(9) != 0) begin
      new_page();
    end
    if ($urandom_range(7) == 0) begin
      put_length_line();
    end else begin
      put_text("HTTP/1.1 ");
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(32, 126)));
    end
    repeat ($urandom_range(0, 4)) begin
      put_byte(ChCr);
      put_byte(ChLf);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: put_length_line();
        5, 6: begin
          k = $urandom_range(0, 13);
          for (int i = 0; i < k; i++) begin
            put_byte(name_text[i]);
          end
          put_byte(8'($urandom_range(255)));
        end
        default: begin
          repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(255)));
        end
      endcase
    end
    // blank line, now and then broken
    case ($urandom_range(19))
      0: begin
        put_byte(ChCr);
        put_byte(ChLf);
        put_byte(ChLf);
      end
      1: begin
        put_byte(ChCr);
        put_byte(ChLf);
        put_byte(ChSpace);
        put_byte(ChCr);
        put_byte(ChLf);
      end
      default: begin
        put_byte(ChCr);
        put_byte(ChLf);
        put_byte(ChCr);
        put_byte(ChLf);
      end
    endcase
    // body sized around the parsed length
    if (len_val != '0 && len_val <= 64) begin
      n = int'(len_val) - 1 + $urandom_range(0, 3);
    end else begin
      n = $urandom_range(0, 24);
    end
    repeat (n) put_byte(8'($urandom_range(255)));
  endtask

  // Hold the sender until every expected result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    dir_row_t row;
    string    hdr_text;
    int       stage;
    int       total;

    // directed table: page start, mixed-case length header, blank line, two body bytes
    row.word  = hsplit_in_t'{kind: KindNewPage, data_byte: 8'hff};
    row.typed = 1'b1;
    row.want  = '0;
    dir_rows.push_back(row);
    hdr_text = "\015\nCONTENT-length:\t1\015\n\015\n";
    foreach (hdr_text[i]) begin
      row.word  = hsplit_in_t'{kind: KindByte, data_byte: hdr_text[i]};
      row.typed = 1'b0;
      row.want  = '0;
      dir_rows.push_back(row);
    end
    row.word  = hsplit_in_t'{kind: KindByte, data_byte: 8'hff};
    row.typed = 1'b1;
    row.want  = hsplit_out_t'{body_valid: 1'b1, body_byte: 8'hff, header_done: 1'b1,
                              body_count: 32'd1, content_length: 32'd1,
                              page_done: 1'b1, overflow: 1'b0};
    dir_rows.push_back(row);
    row.word  = hsplit_in_t'{kind: KindByte, data_byte: 8'h00};
    row.want  = hsplit_out_t'{body_valid: 1'b1, body_byte: 8'h00, header_done: 1'b1,
                              body_count: 32'd2, content_length: 32'd1,
                              page_done: 1'b0, overflow: 1'b1};
    dir_rows.push_back(row);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part in three idling stages
    stage = 0;
    total = words_sent + RandomWords;
    while (words_sent < total) begin
      if (stage == 0 && words_sent >= total - (2 * RandomWords) / 3) begin
        drain();
        src_idle_pct = 63;
        dst_idle_pct = 31;
        stage = 1;
      end else if (stage == 1 && words_sent >= total - RandomWords / 3) begin
        drain();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        stage = 2;
      end
      if ($urandom_range(99) < 8) begin
        put_noise();
      end else begin
        put_page();
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (bad_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
